// File: rtl/core/wauc_pkg.sv
// Package for the weighted age/use cache replacer.
// Holds widths, request and status codes, and the controller command struct.
package wauc_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int USE_BITS = 32;
  localparam int PIN_BITS = 16;
  localparam int AGE_BITS = 32;
  localparam int BIRTH_BITS = 33;
  localparam int SCORE_BITS = 41;
  localparam int LIMIT_BITS = 5;

  localparam logic [1:0] KIND_LOOKUP  = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  localparam logic [3:0] ST_HIT        = 4'd0;
  localparam logic [3:0] ST_MISS       = 4'd1;
  localparam logic [3:0] ST_STALE_REM  = 4'd2;
  localparam logic [3:0] ST_STALE_PIN  = 4'd3;
  localparam logic [3:0] ST_INSERTED   = 4'd4;
  localparam logic [3:0] ST_INS_EVICT  = 4'd5;
  localparam logic [3:0] ST_PRESENT    = 4'd6;
  localparam logic [3:0] ST_INS_GROWN  = 4'd7;
  localparam logic [3:0] ST_NO_ROOM    = 4'd8;
  localparam logic [3:0] ST_RELEASED   = 4'd9;
  localparam logic [3:0] ST_REL_UNDER  = 4'd10;
  localparam logic [3:0] ST_NOT_CACHED = 4'd11;
  localparam logic [3:0] ST_CLEARED    = 4'd12;

  localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_USE_WEIGHT  = 2'd1;
  localparam logic [1:0] CFG_BONUS       = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic apply;
  } wauc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } wauc_stat_t;
endpackage

// File: rtl/core/wauc_ctrl.sv
// Controller for the cache replacer: sequences load, eviction scan and update.
// Depends on wauc_pkg.
module wauc_ctrl
  import wauc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       in_is_insert,
  input  logic       out_busy,
  input  wauc_stat_t stat,
  output wauc_cmd_t  cmd,
  output logic       idle
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = (state == S_IDLE) && !out_busy;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          if (in_is_insert) begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_FLUSH;
      end
      // let the last scored entry reach the comparison
      S_FLUSH: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// File: rtl/core/wauc_datapath.sv
// Datapath for the cache replacer: entry store, age, score scan and result.
// Depends on wauc_pkg; commanded by wauc_ctrl.
module wauc_datapath
  import wauc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wauc_cmd_t             cmd,
  output wauc_stat_t            stat,
  input  logic [1:0]            in_kind,
  input  logic [31:0]           in_key,
  input  logic                  in_time_known,
  input  logic                  in_still_valid,
  input  logic                  in_preferred,
  input  logic                  cfg_fire,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  res_valid,
  input  logic                  res_take,
  output logic [3:0]            res_status,
  output logic [3:0]            res_slot,
  output logic                  res_evicted,
  output logic [31:0]           res_evicted_key
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0]    valid;
  logic [KEY_BITS-1:0] ekey  [DEPTH];
  logic [BIRTH_BITS-1:0] birth [DEPTH];
  logic [USE_BITS-1:0] euse  [DEPTH];
  logic [PIN_BITS-1:0] pins  [DEPTH];
  logic [AGE_BITS-1:0] age;
  logic [LIMIT_BITS-1:0] limit;
  logic [7:0]  use_weight;
  logic [15:0] bonus;

  logic [1:0] kind;
  logic [KEY_BITS-1:0] key;
  logic tk, sv, pref;

  logic [IW-1:0] scan_idx;
  logic win_found;
  logic [IW-1:0] win;
  logic [SCORE_BITS-1:0] best;
  logic [KEY_BITS-1:0] best_key;
  logic [SCORE_BITS-1:0] prod;
  logic [SCORE_BITS-1:0] score;

  assign stat.scan_last = (scan_idx == IW'(DEPTH - 1));

  // match and free slot search over the latched key
  logic hit;
  logic [IW-1:0] hit_idx;
  logic hit_ex;
  logic [IW-1:0] hit_ex_idx;
  logic free_ex;
  logic [IW-1:0] free_ex_idx;
  logic [CW-1:0] count;
  logic [DEPTH-1:0] valid_ev;
  logic full;

  assign full = ({{(32-CW){1'b0}}, count} >= {27'd0, limit})
                || (32'(count) >= 32'(DEPTH));

  always_comb begin
    valid_ev = valid;
    if (full && win_found) valid_ev[win] = 1'b0;
  end

  always_comb begin
    hit = 1'b0; hit_idx = '0;
    hit_ex = 1'b0; hit_ex_idx = '0;
    free_ex = 1'b0; free_ex_idx = '0;
    count = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid[i] && ekey[i] == key) begin
        hit = 1'b1; hit_idx = IW'(i);
      end
      if (valid_ev[i] && ekey[i] == key) begin
        hit_ex = 1'b1; hit_ex_idx = IW'(i);
      end
      if (!valid_ev[i]) begin
        free_ex = 1'b1; free_ex_idx = IW'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) count = count + CW'(valid[i]);
  end

  always_ff @(posedge clk) begin
    prod <= SCORE_BITS'(use_weight) * SCORE_BITS'(euse[scan_idx]);
  end

  // score of the entry at prev_idx, with the registered product
  logic [IW-1:0] prev_idx;
  logic prev_ok;
  assign score = SCORE_BITS'(birth[prev_idx]) + prod;

  logic [AGE_BITS-1:0] age_inc;
  assign age_inc = age + 1'b1;

  logic [LIMIT_BITS-1:0] cfg_lim;
  assign cfg_lim = cfg_data[LIMIT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      age <= '0;
      limit <= LIMIT_BITS'(10);
      use_weight <= 8'd2;
      bonus <= 16'd1000;
      res_valid <= 1'b0;
      prev_ok <= 1'b0;
      win_found <= 1'b0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_MAX_ENTRIES: limit <= cfg_lim;
          CFG_USE_WEIGHT:  use_weight <= cfg_data[7:0];
          CFG_BONUS:       bonus <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        kind <= in_kind;
        key <= KEY_BITS'(in_key);
        tk <= in_time_known;
        sv <= in_still_valid;
        pref <= in_preferred;
        win_found <= 1'b0;
      end
      if (cmd.scan_start) scan_idx <= '0;
      if (cmd.scan_step && !stat.scan_last) scan_idx <= scan_idx + 1'b1;
      prev_idx <= scan_idx;
      prev_ok <= cmd.scan_step && valid[scan_idx] && pins[scan_idx] == '0;
      if (prev_ok) begin
        if (!win_found || score < best || (score == best && ekey[prev_idx] < best_key)) begin
          win_found <= 1'b1;
          win <= prev_idx;
          best <= score;
          best_key <= ekey[prev_idx];
        end
      end
      if (cmd.apply) begin : apply_blk
        logic [3:0] st;
        logic [3:0] slot_n;
        logic ev_n;
        logic [31:0] evk_n;
        logic room;
        logic ins;
        logic wrap;
        logic [DEPTH-1:0] valid_n;
        st = ST_CLEARED;
        slot_n = '0;
        ev_n = 1'b0;
        evk_n = '0;
        room = 1'b1;
        ins = 1'b0;
        wrap = (age_inc == '0);
        valid_n = valid;
        unique case (kind)
          KIND_LOOKUP: begin
            if (!hit || !tk) st = ST_MISS;
            else begin
              slot_n = 4'(hit_idx);
              if (sv) begin
                st = ST_HIT;
                age <= age_inc;
                for (int i = 0; i < DEPTH; i++)
                  if (wrap) birth[i] <= '0;
                if (euse[hit_idx] != '1) euse[hit_idx] <= euse[hit_idx] + 1'b1;
                if (pins[hit_idx] != '1) pins[hit_idx] <= pins[hit_idx] + 1'b1;
              end else if (pins[hit_idx] == '0) begin
                st = ST_STALE_REM;
                valid_n[hit_idx] = 1'b0;
              end else st = ST_STALE_PIN;
            end
          end
          KIND_INSERT: begin
            st = ST_INSERTED;
            age <= age_inc;
            if (full) begin
              if (win_found) begin
                st = ST_INS_EVICT;
                ev_n = 1'b1;
                evk_n = 32'(best_key);
              end else if (32'(limit) < 32'(DEPTH)) begin
                st = ST_INS_GROWN;
                limit <= limit + 1'b1;
              end else room = 1'b0;
            end
            valid_n = valid_ev;
            if (room && hit_ex) begin
              st = ST_PRESENT;
              slot_n = 4'(hit_ex_idx);
            end else if (!room || !free_ex) begin
              st = ST_NO_ROOM;
            end else begin
              ins = 1'b1;
              slot_n = 4'(free_ex_idx);
              valid_n[free_ex_idx] = 1'b1;
              ekey[free_ex_idx] <= key;
              euse[free_ex_idx] <= '0;
              pins[free_ex_idx] <= PIN_BITS'(1);
            end
            for (int i = 0; i < DEPTH; i++) begin
              if (ins && IW'(i) == free_ex_idx)
                birth[i] <= BIRTH_BITS'(age_inc) + (pref ? BIRTH_BITS'(bonus) : '0);
              else if (wrap)
                birth[i] <= '0;
            end
          end
          KIND_RELEASE: begin
            if (!hit) st = ST_NOT_CACHED;
            else begin
              slot_n = 4'(hit_idx);
              if (pins[hit_idx] == '0) st = ST_REL_UNDER;
              else begin
                st = ST_RELEASED;
                pins[hit_idx] <= pins[hit_idx] - 1'b1;
              end
            end
          end
          default: begin
            valid_n = '0;
            st = ST_CLEARED;
          end
        endcase
        valid <= valid_n;
        res_valid <= 1'b1;
        res_status <= st;
        res_slot <= slot_n;
        res_evicted <= ev_n;
        res_evicted_key <= evk_n;
      end
    end
  end
endmodule

// File: rtl/core/weighted_age_use_cache_replacer_core.sv
// Weighted age/use cache replacer, top level.
// Channels: s_axis request in, m_axis result out, cfg register writes.
// Each request gives exactly one result.
// Lookup, release and clear go from load straight to the apply step.
// An insert runs scan and flush before apply; the eviction scan reads one entry
// per cycle through a registered weight-times-use multiplier.
// One request is in flight at a time; s_axis_tready is high when the
// controller is idle and the result register is empty or being taken.
// The result waits in its register while m_axis_tready is low.
// Reset (rst, synchronous, high) invalidates all entries, zeroes the age
// and restores max_entries 10, use_weight 2, preferred_bonus 1000.
// Configuration writes are always accepted; write only while idle.
// Depends on wauc_pkg, wauc_ctrl and wauc_datapath.
module weighted_age_use_cache_replacer_core
  import wauc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0], key[33:2], time_known[34], still_valid[35], preferred[36], zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[3:0], slot[7:4], evicted[8], evicted_key[40:9], zero fill
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  wauc_cmd_t cmd;
  wauc_stat_t stat;
  logic idle, in_fire, res_valid;
  logic [3:0] st, sl;
  logic ev;
  logic [31:0] evk;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata = {7'd0, evk, ev, sl, st};

  wauc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_is_insert(s_axis_tdata[1:0] == KIND_INSERT),
    .out_busy(res_valid && !m_axis_tready),
    .stat(stat), .cmd(cmd), .idle(idle)
  );

  wauc_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_kind(s_axis_tdata[1:0]), .in_key(s_axis_tdata[33:2]),
    .in_time_known(s_axis_tdata[34]), .in_still_valid(s_axis_tdata[35]),
    .in_preferred(s_axis_tdata[36]),
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_take(m_axis_tready),
    .res_status(st), .res_slot(sl), .res_evicted(ev), .res_evicted_key(evk)
  );
endmodule

// File: rtl/core/wauc_checker.sv
// Port checker for the cache replacer top level, with its bind.
// Depends on wauc_pkg.
module wauc_checker
  import wauc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= ST_CLEARED)
    else $error("status code out of range");
  a_evict_key: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[40:9] == 32'd0)
    else $error("evicted key without eviction");
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind weighted_age_use_cache_replacer_core wauc_checker u_wauc_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
